// ----- hdl/deadline_ordered_timer_table_top_defines.svh -----
// Assertion macros for the timer table
`ifndef DEADLINE_ORDERED_TIMER_TABLE_TOP_DEFINES_SVH
`define DEADLINE_ORDERED_TIMER_TABLE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check an implication on every clock edge outside reset
`define TDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer table check failed");
// Check an implication in the next cycle
`define TDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer table check failed");
`else
`define TDT_ASSERT_IMP(lbl, ante, cons)
`define TDT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/tdt_pkg.sv -----
`timescale 1ns / 1ps
package tdt_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int EXP_W = 48;
    localparam int ID_W  = 32;
    localparam int DLY_W = 31;
    localparam int ENT_W = EXP_W + ID_W;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DEL    = 2'd1;
    localparam logic [1:0] OP_HANDLE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] K_ADDED    = 3'd0;
    localparam logic [2:0] K_DELETED  = 3'd1;
    localparam logic [2:0] K_NOTFOUND = 3'd2;
    localparam logic [2:0] K_FULL     = 3'd3;
    localparam logic [2:0] K_EXPIRED  = 3'd4;
    localparam logic [2:0] K_DONE     = 3'd5;
endpackage

// ----- hdl/deadline_ordered_timer_table_top.sv -----
`timescale 1ns / 1ps
// Timer table: each command scans all CAPACITY slots through the entry memory
// (one slot per cycle, registered read); add and delete give a single result
// each. A handle runs one scan for the next deadline, then one scan per expired
// timer and a final scan that finds none, ending with a done result.
// busy falls as the last result shows, so a new command waits for that result.
// No result stall. Synchronous active-low reset clears valid bits, id counter, control.
`include "deadline_ordered_timer_table_top_defines.svh"
module deadline_ordered_timer_table_top #(
    parameter int CAPACITY = tdt_pkg::CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_opcode,
    input  logic [tdt_pkg::EXP_W-1:0] i_now_ms,
    input  logic [tdt_pkg::DLY_W-1:0] i_delay_ms,
    input  logic [tdt_pkg::EXP_W-1:0] i_target_expire,
    input  logic [tdt_pkg::ID_W-1:0]  i_target_id,
    output logic                      o_valid,
    output logic [2:0]                o_kind,
    output logic [tdt_pkg::ID_W-1:0]  o_entry_id,
    output logic [tdt_pkg::EXP_W-1:0] o_entry_expire,
    output logic [tdt_pkg::EXP_W-1:0] o_next_deadline,
    output logic                      o_deadline_valid,
    output logic                      o_last
);
    localparam int EW = tdt_pkg::EXP_W;
    localparam int IW = tdt_pkg::ID_W;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CNT_END = CW'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          r_state;
    logic                r_phase2;
    logic [CW-1:0]       r_cnt;
    logic [CAPACITY-1:0] r_used;
    logic [IW-1:0]       r_ident;
    logic [1:0]          r_op;
    logic [EW-1:0]       r_now;
    logic [EW-1:0]       r_e;
    logic [EW-1:0]       r_texp;
    logic [IW-1:0]       r_tid;
    logic                r_found;
    logic [AW-1:0]       r_fidx;
    logic                r_free_v;
    logic [AW-1:0]       r_free;
    logic                r_dv;
    logic [EW-1:0]       r_dl;
    logic                r_mv;
    logic [EW-1:0]       r_mexp;
    logic [IW-1:0]       r_mid;
    logic [AW-1:0]       r_midx;
    logic                r_valid;
    logic [2:0]          r_kind;
    logic [IW-1:0]       r_oid;
    logic [EW-1:0]       r_oexp;
    logic [EW-1:0]       r_odl;
    logic                r_odv;
    logic                r_last;

    logic                    accept;
    logic [EW:0]             sum;
    logic [EW-1:0]           sat_e;
    logic [tdt_pkg::ENT_W-1:0] rdata;
    logic [EW-1:0]           d_exp;
    logic [IW-1:0]           d_id;
    logic [AW-1:0]           pidx;
    logic                    proc;
    logic                    u;
    logic [EW-1:0]           kexp;
    logic [IW-1:0]           kid;
    logic                    hit;
    logic                    dl_cand;
    logic                    key_cand;
    logic                    key_less;
    logic                    we;
    logic [CW-1:0]           cnt_m1;
    logic [EW-1:0]           add_dl;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // saturate now plus delay at the top of the range
    assign sum   = {1'b0, i_now_ms} + {{(EW + 1 - tdt_pkg::DLY_W){1'b0}}, i_delay_ms};
    assign sat_e = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];

    // slot scan datapath
    assign cnt_m1 = r_cnt - CW'(1);
    assign pidx   = cnt_m1[AW-1:0];
    assign proc   = (r_state == ST_SCAN) && (r_cnt != '0);
    assign d_exp  = rdata[tdt_pkg::ENT_W-1:IW];
    assign d_id   = rdata[IW-1:0];
    assign u      = r_used[pidx];
    assign kexp   = (r_op == tdt_pkg::OP_ADD) ? r_e : r_texp;
    assign kid    = (r_op == tdt_pkg::OP_ADD) ? r_ident : r_tid;
    assign hit    = u && (d_exp == kexp) && (d_id == kid);
    assign key_less = !r_mv || (d_exp < r_mexp) || ((d_exp == r_mexp) && (d_id < r_mid));

    always_comb begin
        dl_cand  = 1'b0;
        key_cand = 1'b0;
        case (r_op)
            tdt_pkg::OP_ADD:    dl_cand = u;
            tdt_pkg::OP_DEL:    dl_cand = u && !hit;
            tdt_pkg::OP_HANDLE: begin
                dl_cand  = !r_phase2 && u && (d_exp > r_now);
                key_cand = r_phase2 && u && (d_exp <= r_now);
            end
            default: begin
                dl_cand  = 1'b0;
                key_cand = 1'b0;
            end
        endcase
    end

    // deadline after an insert
    assign add_dl = (r_dv && (r_dl < r_e)) ? r_dl : r_e;

    // write a new entry on a successful add
    assign we = (r_state == ST_FIN) && (r_op == tdt_pkg::OP_ADD) && !r_found && r_free_v;

    tdt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .W     (tdt_pkg::ENT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_free),
        .i_wdata ({r_e, r_ident}),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rdata)
    );

    // control and scan accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase2 <= 1'b0;
            r_cnt    <= '0;
            r_used   <= '0;
            r_ident  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_opcode != tdt_pkg::OP_NOP)) begin
                        r_op     <= i_opcode;
                        r_now    <= i_now_ms;
                        r_e      <= sat_e;
                        r_texp   <= i_target_expire;
                        r_tid    <= i_target_id;
                        r_phase2 <= 1'b0;
                        r_cnt    <= '0;
                        r_found  <= 1'b0;
                        r_free_v <= 1'b0;
                        r_dv     <= 1'b0;
                        r_dl     <= '0;
                        r_mv     <= 1'b0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (proc) begin
                        if (hit && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= pidx;
                        end
                        if (!u && !r_free_v) begin
                            r_free_v <= 1'b1;
                            r_free   <= pidx;
                        end
                        if (dl_cand && (!r_dv || (d_exp < r_dl))) begin
                            r_dv <= 1'b1;
                            r_dl <= d_exp;
                        end
                        if (key_cand && key_less) begin
                            r_mv   <= 1'b1;
                            r_mexp <= d_exp;
                            r_mid  <= d_id;
                            r_midx <= pidx;
                        end
                    end
                    if (r_cnt == CNT_END) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_FIN: begin
                    r_odl <= r_dl;
                    r_odv <= r_dv;
                    r_oid  <= '0;
                    r_oexp <= '0;
                    r_last <= 1'b1;
                    r_state <= ST_IDLE;
                    case (r_op)
                        tdt_pkg::OP_ADD: begin
                            r_valid <= 1'b1;
                            if (r_found || r_free_v) begin
                                r_kind  <= tdt_pkg::K_ADDED;
                                r_oid   <= r_ident;
                                r_oexp  <= r_e;
                                r_ident <= r_ident + IW'(1);
                                if (!r_found) begin
                                    r_used[r_free] <= 1'b1;
                                    r_odl <= add_dl;
                                    r_odv <= 1'b1;
                                end
                            end else begin
                                r_kind <= tdt_pkg::K_FULL;
                            end
                        end
                        tdt_pkg::OP_DEL: begin
                            r_valid <= 1'b1;
                            if (r_found) begin
                                r_used[r_fidx] <= 1'b0;
                                r_kind <= tdt_pkg::K_DELETED;
                            end else begin
                                r_kind <= tdt_pkg::K_NOTFOUND;
                            end
                        end
                        tdt_pkg::OP_HANDLE: begin
                            r_cnt <= '0;
                            r_mv  <= 1'b0;
                            if (!r_phase2) begin
                                // deadline known; start draining expiries
                                r_phase2 <= 1'b1;
                                r_state  <= ST_SCAN;
                            end else if (r_mv) begin
                                r_valid <= 1'b1;
                                r_kind  <= tdt_pkg::K_EXPIRED;
                                r_oid   <= r_mid;
                                r_oexp  <= r_mexp;
                                r_last  <= 1'b0;
                                r_used[r_midx] <= 1'b0;
                                r_state <= ST_SCAN;
                            end else begin
                                r_valid <= 1'b1;
                                r_kind  <= tdt_pkg::K_DONE;
                            end
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_entry_id       = r_oid;
    assign o_entry_expire   = r_oexp;
    assign o_next_deadline  = r_odl;
    assign o_deadline_valid = r_odv;
    assign o_last           = r_last;

    `TDT_ASSERT_NXT(a_start_busy, accept && (i_opcode != tdt_pkg::OP_NOP), busy)
    `TDT_ASSERT_IMP(a_last_idle, o_valid && o_last, !busy)
    `TDT_ASSERT_IMP(a_more_busy, o_valid && !o_last, busy)
    `TDT_ASSERT_IMP(a_exp_not_last, o_valid && (o_kind == tdt_pkg::K_EXPIRED), !o_last)
    `TDT_ASSERT_IMP(a_dl_zero, o_valid && !o_deadline_valid, o_next_deadline == '0)
endmodule

// ----- hdl/tdt_mem.sv -----
`timescale 1ns / 1ps
module tdt_mem #(
    parameter int DEPTH = tdt_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(tdt_pkg::CAPACITY_DEF),
    parameter int W     = tdt_pkg::ENT_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    localparam int          SLOTS   = tdt_pkg::CAPACITY_DEF;
    localparam logic [47:0] TOP48   = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [47:0] expire;
        logic [47:0] deadline;
        logic        dl_valid;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [47:0] i_now_ms;
    logic [30:0] i_delay_ms;
    logic [47:0] i_target_expire;
    logic [31:0] i_target_id;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [31:0] o_entry_id;
    logic [47:0] o_entry_expire;
    logic [47:0] o_next_deadline;
    logic        o_deadline_valid;
    logic        o_last;

    // shadow copy of the timer table
    logic [47:0] tbl_exp [SLOTS];
    logic [31:0] tbl_id  [SLOTS];
    logic        tbl_used[SLOTS];
    logic [31:0] id_ctr;

    t_result     want_q[$];
    int          errors;
    int          n_sent;
    int          n_results;
    int          n_expired;
    int          n_full;
    bit          calm;
    logic [47:0] clock_ms;

    deadline_ordered_timer_table_top dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // earliest pending timer, -1 when the table is empty
    function automatic int earliest();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_used[i]) continue;
            if (best < 0 || tbl_exp[i] < tbl_exp[best] ||
                (tbl_exp[i] == tbl_exp[best] && tbl_id[i] < tbl_id[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic int find_entry(input logic [47:0] e, input logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_exp[i] == e && tbl_id[i] == id) return i;
        return -1;
    endfunction

    // advance the shadow table by one command and queue its results
    task automatic table_step(input logic [1:0] op, input logic [47:0] now,
                              input logic [30:0] dly, input logic [47:0] texp,
                              input logic [31:0] tid);
        t_result     res[$];
        t_result     r;
        logic [48:0] sum;
        logic [47:0] e;
        int          m;
        int          fr;
        r = '0;
        if (op == tdt_pkg::OP_ADD) begin
            sum = {1'b0, now} + {18'd0, dly};
            e   = sum[48] ? TOP48 : sum[47:0];
            fr  = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!tbl_used[i]) fr = i;
            if (find_entry(e, id_ctr) >= 0 || fr >= 0) begin
                if (find_entry(e, id_ctr) < 0) begin
                    tbl_used[fr] = 1'b1;
                    tbl_exp[fr]  = e;
                    tbl_id[fr]   = id_ctr;
                end
                r.kind = tdt_pkg::K_ADDED; r.id = id_ctr; r.expire = e;
                id_ctr++;
            end else begin
                r.kind = tdt_pkg::K_FULL;
                n_full++;
            end
            res.push_back(r);
        end else if (op == tdt_pkg::OP_DEL) begin
            m = find_entry(texp, tid);
            if (m >= 0) tbl_used[m] = 1'b0;
            r.kind = (m >= 0) ? tdt_pkg::K_DELETED : tdt_pkg::K_NOTFOUND;
            res.push_back(r);
        end else if (op == tdt_pkg::OP_HANDLE) begin
            forever begin
                m = earliest();
                if (m < 0 || tbl_exp[m] > now) break;
                r.kind = tdt_pkg::K_EXPIRED; r.id = tbl_id[m]; r.expire = tbl_exp[m];
                res.push_back(r);
                tbl_used[m] = 1'b0;
                n_expired++;
            end
            r = '0;
            r.kind = tdt_pkg::K_DONE;
            res.push_back(r);
        end else begin
            return;
        end
        m = earliest();
        foreach (res[i]) begin
            res[i].deadline = (m >= 0) ? tbl_exp[m] : 48'd0;
            res[i].dl_valid = (m >= 0);
            res[i].last     = (i == res.size() - 1);
            want_q.push_back(res[i]);
        end
    endtask

    // drive one command and wait until the block takes it; call at a rising edge
    task automatic send_cmd(input logic [1:0] op, input logic [47:0] now,
                            input logic [30:0] dly, input logic [47:0] texp,
                            input logic [31:0] tid);
        int gap;
        gap = (!calm && $urandom_range(99) < 12) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_opcode        <= op;
        i_now_ms        <= now;
        i_delay_ms      <= dly;
        i_target_expire <= texp;
        i_target_id     <= tid;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        table_step(op, now, dly, texp, tid);
        n_sent++;
    endtask

    // compare each result transaction with the oldest expectation
    always @(negedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid) begin
            got = {o_kind, o_entry_id, o_entry_expire, o_next_deadline,
                   o_deadline_valid, o_last};
            n_results++;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected result, got %h", $realtime, got);
                errors++;
            end else begin
                want = want_q.pop_front();
                if (got.kind !== want.kind) begin
                    $display("%0t: kind exp %0d got %0d", $realtime, want.kind, got.kind);
                    errors++;
                end
                if (got.id !== want.id) begin
                    $display("%0t: entry_id exp %h got %h", $realtime, want.id, got.id);
                    errors++;
                end
                if (got.expire !== want.expire) begin
                    $display("%0t: entry_expire exp %h got %h", $realtime,
                             want.expire, got.expire);
                    errors++;
                end
                if (got.deadline !== want.deadline) begin
                    $display("%0t: next_deadline exp %h got %h", $realtime,
                             want.deadline, got.deadline);
                    errors++;
                end
                if (got.dl_valid !== want.dl_valid) begin
                    $display("%0t: deadline_valid exp %b got %b", $realtime,
                             want.dl_valid, got.dl_valid);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last exp %b got %b", $realtime, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // extremes, every opcode, overflow, delete hit and miss, ignored opcode, full table
    task automatic test_directed();
        send_cmd(tdt_pkg::OP_HANDLE, 48'd0, 31'd0, 48'd0, 32'd0);
        send_cmd(tdt_pkg::OP_DEL, 48'd0, 31'd0, TOP48, 32'hFFFF_FFFF);
        send_cmd(tdt_pkg::OP_ADD, 48'd0, 31'd0, 48'd0, 32'd0);
        send_cmd(tdt_pkg::OP_ADD, 48'd0, 31'h7FFF_FFFF, 48'd0, 32'd0);
        send_cmd(tdt_pkg::OP_ADD, TOP48, 31'h7FFF_FFFF, TOP48, 32'hFFFF_FFFF);
        send_cmd(tdt_pkg::OP_ADD, TOP48 - 48'd5, 31'd3, 48'd0, 32'd0);
        send_cmd(tdt_pkg::OP_DEL, TOP48, 31'h7FFF_FFFF, 48'd0, 32'd1);
        send_cmd(tdt_pkg::OP_DEL, 48'd0, 31'd0, 48'd0, 32'd0);
        send_cmd(tdt_pkg::OP_DEL, 48'd0, 31'd0, TOP48, 32'd2);
        send_cmd(tdt_pkg::OP_NOP, TOP48, 31'h7FFF_FFFF, TOP48, 32'hFFFF_FFFF);
        send_cmd(tdt_pkg::OP_HANDLE, 48'h7FFF_FFFF, 31'd0, 48'd0, 32'd0);
        repeat (SLOTS + 1)
            send_cmd(tdt_pkg::OP_ADD, 48'd100, 31'($urandom_range(9)), 48'd0, 32'd0);
        send_cmd(tdt_pkg::OP_HANDLE, TOP48, 31'd0, 48'd0, 32'd0);
    endtask

    // mostly coherent traffic on a moving clock, plus full-range noise
    task automatic test_random(input int count);
        int          pick;
        int          live[$];
        logic [47:0] now;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3 && n < count / 2);
            clock_ms += $urandom_range(6);
            now  = clock_ms;
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_cmd(2'($urandom_range(3)), {$urandom, $urandom},
                         31'($urandom), {$urandom, $urandom}, $urandom);
            end else if (pick < 55) begin
                send_cmd(tdt_pkg::OP_ADD, now,
                         ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40)),
                         48'd0, 32'd0);
            end else if (pick < 75) begin
                live.delete();
                for (int i = 0; i < SLOTS; i++) if (tbl_used[i]) live.push_back(i);
                if (live.size() > 0 && $urandom_range(3) != 0) begin
                    pick = live[$urandom_range(live.size() - 1)];
                    send_cmd(tdt_pkg::OP_DEL, now, 31'd0, tbl_exp[pick],
                             tbl_id[pick] ^ ($urandom_range(7) == 0));
                end else begin
                    send_cmd(tdt_pkg::OP_DEL, now, 31'd0, now + $urandom_range(40),
                             id_ctr - 1);
                end
            end else begin
                send_cmd(tdt_pkg::OP_HANDLE, now, 31'($urandom), 48'd0, 32'd0);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int waited;
        errors = 0; n_sent = 0; n_results = 0; n_expired = 0; n_full = 0;
        calm = 1'b0; clock_ms = 48'd0; id_ctr = 32'd0;
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        i_rst_n = 1'b0; start = 1'b0; i_opcode = tdt_pkg::OP_ADD; i_now_ms = '0;
        i_delay_ms = '0; i_target_expire = '0; i_target_id = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        start <= 1'b0;
        waited = 0;
        while (want_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        if (want_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, want_q.size());
            errors++;
        end
        repeat (400) @(posedge i_clk);
        $display("Sent %0d commands, checked %0d results (%0d expiries, %0d table-full).",
                 n_sent, n_results, n_expired, n_full);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/tdt_pkg.sv
hdl/tdt_mem.sv
hdl/deadline_ordered_timer_table_top.sv
verif/testbench.sv
